### design/lskv_pkg.sv
// ----------------------------------------------------------------------------
// Log-structured key/value store: shared definitions
// Field widths, command and status codes, sequencer state and the status
// group passed from the sequencer to the top level.
// ----------------------------------------------------------------------------
package lskv_pkg;

    // Field widths of one input word and one result word.
    localparam int CMD_W  = 2;
    localparam int KEY_W  = 16;
    localparam int DATA_W = 64;
    localparam int CNT_W  = 4;
    localparam int STAT_W = 2;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 72;
    localparam int M_PAD_W   = M_TDATA_W - STAT_W - DATA_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_DONE
    } seq_state_t;

    // Status group from the sequencer.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } seq_stat_t;

endpackage

### design/lskv_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module lskv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

### design/lskv_seq.sv
// ----------------------------------------------------------------------------
// Log-structured key/value store: command sequencer
// Appends blocks, scans the log backward with one shared tag comparator
// (one block per cycle) and holds the result until the output takes it.
// ----------------------------------------------------------------------------
module lskv_seq import lskv_pkg::*; #(
    parameter int NUM_BLOCKS    = 64,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic [CMD_W-1:0]                          in_cmd,
    input  logic [KEY_W-1:0]                          in_key,
    input  logic [DATA_W-1:0]                         in_payload,
    input  logic [CNT_W-1:0]                          in_count,
    input  logic                                      res_taken,
    output seq_stat_t                                 stat,
    output logic [STAT_W-1:0]                         res_status,
    output logic [DATA_W-1:0]                         res_data,
    output logic                                      ram_we,
    output logic [$clog2(NUM_BLOCKS)-1:0]             ram_waddr,
    output logic [KEY_W+8*PAYLOAD_BYTES-1:0]          ram_wdata,
    output logic [$clog2(NUM_BLOCKS)-1:0]             ram_raddr,
    input  logic [KEY_W+8*PAYLOAD_BYTES-1:0]          ram_rdata
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int PW = 8 * PAYLOAD_BYTES;
    localparam logic [CNT_W-1:0] PB_CNT = CNT_W'(PAYLOAD_BYTES);
    localparam logic [CW-1:0]    FULL_CNT = CW'(NUM_BLOCKS);

    seq_state_t          state_reg, state_next;
    logic [CW-1:0]       slot_reg, slot_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;

    logic [AW-1:0]       slot_m1;
    logic [CNT_W-1:0]    cnt_sat;
    logic [PW-1:0]       wr_payload;
    logic [DATA_W-1:0]   rd_padded;

    // Byte masking of the write data; unwritten bytes stay erased.
    always_comb begin
        cnt_sat = (in_count > PB_CNT) ? PB_CNT : in_count;
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            wr_payload[8*b +: 8] = (CNT_W'(b) < cnt_sat) ? in_payload[8*b +: 8] : 8'hFF;
        end
    end

    // Stored payload widened to the result width; bytes beyond the block read erased.
    always_comb begin
        rd_padded = '1;
        rd_padded[PW-1:0] = ram_rdata[KEY_W +: PW];
    end

    assign slot_m1 = AW'(slot_reg - 1'b1);

    // Next state and RAM control.
    always_comb begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot_reg[AW-1:0];
        ram_wdata       = {wr_payload, in_key};
        ram_raddr       = (state_reg == SEQ_SCAN) ? AW'(cur_reg - 1'b1) : slot_m1;

        unique case (state_reg)
            SEQ_IDLE: begin
                if (start) begin
                    key_next = in_key;
                    unique case (in_cmd)
                        CMD_WRITE: begin
                            res_data_next = '0;
                            if (slot_reg == FULL_CNT) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                ram_we          = 1'b1;
                                slot_next       = slot_reg + 1'b1;
                                res_status_next = STAT_OK;
                            end
                            state_next = SEQ_DONE;
                        end
                        CMD_READ: begin
                            if (slot_reg == '0) begin
                                res_status_next = STAT_MISS;
                                res_data_next   = '1;
                                state_next      = SEQ_DONE;
                            end else begin
                                // Newest block's read is issued this cycle.
                                cur_next   = slot_m1;
                                state_next = SEQ_SCAN;
                            end
                        end
                        CMD_ERASE: begin
                            slot_next       = '0;
                            res_status_next = STAT_OK;
                            res_data_next   = '0;
                            state_next      = SEQ_DONE;
                        end
                        default: begin
                            res_status_next = STAT_OK;
                            res_data_next   = '0;
                            state_next      = SEQ_DONE;
                        end
                    endcase
                end
            end
            SEQ_SCAN: begin
                // The read port holds the block at cur_reg.
                if (ram_rdata[KEY_W-1:0] == key_reg) begin
                    res_status_next = STAT_OK;
                    res_data_next   = rd_padded;
                    state_next      = SEQ_DONE;
                end else if (cur_reg == '0) begin
                    res_status_next = STAT_MISS;
                    res_data_next   = '1;
                    state_next      = SEQ_DONE;
                end else begin
                    cur_next = cur_reg - 1'b1;
                end
            end
            SEQ_DONE: begin
                if (res_taken) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
    end

    assign stat.idle      = (state_reg == SEQ_IDLE);
    assign stat.res_valid = (state_reg == SEQ_DONE);
    assign res_status     = res_status_reg;
    assign res_data       = res_data_reg;

endmodule

### design/log_structured_key_value_store.sv
// ----------------------------------------------------------------------------
// Log-structured key/value store (flash EEPROM emulation)
// Append-only log of tagged blocks with write, newest-first read and erase.
// ----------------------------------------------------------------------------
//  Channel  | Ports                     | tdata fields, low bit first
//  ---------+---------------------------+--------------------------------------
//  input    | s_tvalid s_tready s_tdata | cmd[1:0] key[17:2] payload[81:18]
//           |                           | byte_count[85:82], zero to bit 87
//  result   | m_tvalid m_tready m_tdata | status[1:0] read_data[65:2],
//           |                           | zero to bit 71
//
// Write, erase and unused commands pass from acceptance to the done state and
// then into the output register. A read scans k blocks, k at most NUM_BLOCKS,
// newest first: the single RAM read port delivers one tag per cycle.
// Reset empties the log at once; stale RAM contents are never scanned.
// The input is taken only while the sequencer is idle; a result waiting in
// the output register does not block the next word's acceptance.
// ----------------------------------------------------------------------------
module log_structured_key_value_store import lskv_pkg::*; #(
    parameter int NUM_BLOCKS    = 64,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // cmd, key, payload, byte_count
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, read_data
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int RW = KEY_W + 8 * PAYLOAD_BYTES;

    seq_stat_t          stat;
    logic               start;
    logic               load;
    logic [STAT_W-1:0]  res_status;
    logic [DATA_W-1:0]  res_data;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [RW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [RW-1:0]      ram_rdata;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0]  m_status_reg;
    logic [DATA_W-1:0]  m_data_reg;

    assign s_tready = stat.idle;
    assign start    = s_tvalid && stat.idle;

    // Sequencer with the shared tag comparator.
    lskv_seq #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .in_cmd     (s_tdata[CMD_W-1:0]),
        .in_key     (s_tdata[CMD_W +: KEY_W]),
        .in_payload (s_tdata[CMD_W+KEY_W +: DATA_W]),
        .in_count   (s_tdata[CMD_W+KEY_W+DATA_W +: CNT_W]),
        .res_taken  (load),
        .stat       (stat),
        .res_status (res_status),
        .res_data   (res_data),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // Block store: tag in the low bits, payload above.
    lskv_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register loads when empty or being drained.
    always_comb begin
        load          = stat.res_valid && (!m_tvalid_reg || m_tready);
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_status_reg <= res_status;
            m_data_reg   <= res_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_data_reg, m_status_reg};

endmodule

### sim/tb_log_structured_key_value_store.sv
// ----------------------------------------------------------------------------
// Testbench for the log-structured key/value store
// Feeds write, read, erase and unused command words through the input
// stream, keeps a behavioral copy of the block log and checks every result
// word against it. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_log_structured_key_value_store import lskv_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS    = 64;
    localparam int PAYLOAD_BYTES = 8;
    localparam int S_PAD_W       = S_TDATA_W - CMD_W - KEY_W - DATA_W - CNT_W;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_RESERVED = 16'hFFFF;
    localparam int RANDOM_WORDS = 1500;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
        logic [CNT_W-1:0]  nbytes;
    } kv_cmd_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] rdata;
    } kv_resp_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // cmd, key, payload, byte_count
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // status, read_data, zero pad

    kv_cmd_t  pending_cmds[$];
    kv_resp_t expected_resp[$];
    int       err_cnt = 0;

    // Behavioral copy of the log.
    logic [KEY_W-1:0]  tag_log[NUM_BLOCKS];
    logic [DATA_W-1:0] data_log[NUM_BLOCKS];
    int                log_fill;

    log_structured_key_value_store #(
        .NUM_BLOCKS   (NUM_BLOCKS),
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Return every block to the erased state and restart the log.
    function automatic void wipe_log();
        int i;
        for (i = 0; i < NUM_BLOCKS; i++) begin
            tag_log[i]  = '1;
            data_log[i] = '1;
        end
        log_fill = 0;
    endfunction

    // Apply one accepted command word to the log and return its result.
    function automatic kv_resp_t store_update(kv_cmd_t c);
        kv_resp_t          res;
        int                nb;
        int                b;
        int                s;
        bit                hit;
        logic [DATA_W-1:0] blk;
        res.status = STAT_OK;
        res.rdata  = '0;
        case (c.cmd)
            CMD_WRITE: begin
                if (log_fill >= NUM_BLOCKS) begin
                    res.status = STAT_FULL;
                end else begin
                    nb  = (c.nbytes > PAYLOAD_BYTES) ? PAYLOAD_BYTES : int'(c.nbytes);
                    blk = '1;
                    for (b = 0; b < nb; b++)
                        blk[8*b +: 8] = c.payload[8*b +: 8];
                    tag_log[log_fill]  = c.key;
                    data_log[log_fill] = blk;
                    log_fill++;
                end
            end
            CMD_READ: begin
                hit = 1'b0;
                // Newest block wins, so scan from the top of the log down.
                for (s = log_fill - 1; s >= 0 && !hit; s--) begin
                    if (tag_log[s] == c.key) begin
                        res.rdata = data_log[s];
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    res.status = STAT_MISS;
                    res.rdata  = '1;
                end
            end
            CMD_ERASE: wipe_log();
            default: ;
        endcase
        return res;
    endfunction

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                             logic [DATA_W-1:0] payload, logic [CNT_W-1:0] nbytes);
        kv_cmd_t c;
        c.cmd     = cmd;
        c.key     = key;
        c.payload = payload;
        c.nbytes  = nbytes;
        pending_cmds.push_back(c);
    endtask

    task automatic report(string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Input side: bursts of words separated by random gaps.
    int gap_left   = 0;
    int burst_left = 0;

    always @(posedge aclk) begin
        logic                 next_valid;
        logic [S_TDATA_W-1:0] next_data;
        kv_cmd_t              c;
        next_valid = s_tvalid;
        next_data  = s_tdata;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_resp.push_back(store_update(pending_cmds[0]));
                void'(pending_cmds.pop_front());
            end
            // A word still waiting for acceptance must stay on the bus.
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    next_valid = 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c          = pending_cmds[0];
                    next_valid = 1'b1;
                    next_data  = {{S_PAD_W{1'b0}}, c.nbytes, c.payload, c.key, c.cmd};
                    if (burst_left <= 1) begin
                        if ($urandom_range(0, 4) == 0) begin
                            burst_left = $urandom_range(20, 60);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = ($urandom_range(0, 3) == 0) ?
                                         $urandom_range(10, 80) : $urandom_range(0, 3);
                        end
                    end else begin
                        burst_left--;
                    end
                end else begin
                    next_valid = 1'b0;
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
    end

    // Result side: ready follows one of several stall modes, switched now and then.
    int         ready_mode  = 0;
    int         ready_hold  = 0;
    int         ready_phase = 0;
    logic [7:0] stall_mask  = 8'b1011_0010;

    always @(posedge aclk) begin
        logic     next_ready;
        kv_resp_t want;
        kv_resp_t got;
        if (!aresetn) begin
            next_ready = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[STAT_W-1:0];
                got.rdata  = m_tdata[STAT_W +: DATA_W];
                if (expected_resp.size() == 0) begin
                    report($sformatf("result word with none expected: status %0d data %h",
                                     got.status, got.rdata));
                end else begin
                    want = expected_resp.pop_front();
                    if (got.status !== want.status)
                        report($sformatf("status: expected %0d, got %0d",
                                         want.status, got.status));
                    if (got.rdata !== want.rdata)
                        report($sformatf("read_data: expected %h, got %h",
                                         want.rdata, got.rdata));
                    if (m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0)
                        report($sformatf("pad bits: expected 0, got %h",
                                         m_tdata[M_TDATA_W-1 -: M_PAD_W]));
                end
            end
            if (ready_hold == 0) begin
                ready_mode = $urandom_range(0, 3);
                ready_hold = $urandom_range(16, 200);
            end else begin
                ready_hold--;
            end
            ready_phase++;
            case (ready_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = ($urandom_range(0, 3) != 0);
                2:       next_ready = stall_mask[ready_phase % 8];
                default: next_ready = (ready_phase % 12 == 0);
            endcase
        end
        m_tready <= next_ready;
    end

    // Stimulus and end of run.
    initial begin
        int               total;
        int               burst_len;
        int               n;
        int               pick;
        int               pool_size;
        logic [KEY_W-1:0] key_pool[8];
        logic [KEY_W-1:0] k;
        logic [CNT_W-1:0] nb;

        wipe_log();

        // Directed words: empty reads, field extremes, reserved key,
        // oversized byte count, unused command and reads after erase.
        queue_cmd(CMD_READ,   16'h0000,     '0,                    4'd0);
        queue_cmd(CMD_WRITE,  16'h0000,     '0,                    4'd8);
        queue_cmd(CMD_READ,   16'h0000,     '0,                    4'd0);
        queue_cmd(CMD_WRITE,  16'hFFFE,     '1,                    4'd0);
        queue_cmd(CMD_WRITE,  KEY_RESERVED, 64'h0123_4567_89AB_CDEF, 4'd3);
        queue_cmd(CMD_READ,   KEY_RESERVED, '0,                    4'd0);
        queue_cmd(CMD_WRITE,  16'h0000,     64'hA5C3_5A3C_9669_0FF0, 4'd15);
        queue_cmd(CMD_READ,   16'h0000,     '1,                    4'd15);
        queue_cmd(CMD_READ,   16'hFFFE,     '0,                    4'd0);
        queue_cmd(CMD_WRITE,  16'h1234,     64'hFEDC_BA98_7654_3210, 4'd1);
        queue_cmd(CMD_WRITE,  16'h1234,     64'h1122_3344_5566_7788, 4'd7);
        queue_cmd(CMD_READ,   16'h1234,     '0,                    4'd0);
        queue_cmd(CMD_WRITE,  16'h8001,     64'h0F0F_F0F0_0F0F_F0F0, 4'd9);
        queue_cmd(CMD_READ,   16'h8001,     '0,                    4'd0);
        queue_cmd(CMD_UNUSED, '1,           '1,                    4'd15);
        queue_cmd(CMD_READ,   16'h4321,     '0,                    4'd0);
        queue_cmd(CMD_ERASE,  '1,           '1,                    4'd15);
        queue_cmd(CMD_READ,   16'h0000,     '0,                    4'd0);
        queue_cmd(CMD_READ,   KEY_RESERVED, '0,                    4'd0);

        // Random part: episodes over a small key pool so that reads mostly
        // hit, long enough that the log often runs full.
        total = 0;
        while (total < RANDOM_WORDS) begin
            pool_size = $urandom_range(1, 8);
            for (n = 0; n < pool_size; n++)
                key_pool[n] = ($urandom_range(0, 15) == 0) ? KEY_RESERVED :
                              KEY_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 0) begin
                queue_cmd(CMD_ERASE, KEY_W'($urandom), {$urandom, $urandom},
                          CNT_W'($urandom));
                total++;
            end
            burst_len = $urandom_range(20, 120);
            for (n = 0; n < burst_len; n++) begin
                pick = $urandom_range(0, 99);
                k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_size - 1)]
                                               : KEY_W'($urandom_range(0, 65535));
                nb = ($urandom_range(0, 9) < 7) ? CNT_W'(PAYLOAD_BYTES)
                                                : CNT_W'($urandom_range(0, 15));
                if (pick < 52)
                    queue_cmd(CMD_WRITE, k, {$urandom, $urandom}, nb);
                else if (pick < 95)
                    queue_cmd(CMD_READ, k, {$urandom, $urandom}, CNT_W'($urandom));
                else if (pick < 99)
                    queue_cmd(CMD_UNUSED, k, {$urandom, $urandom}, nb);
                else
                    queue_cmd(CMD_ERASE, k, {$urandom, $urandom}, nb);
            end
            total += burst_len;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (expected_resp.size() > 0)
            @(posedge aclk);
        // Room for a late or spurious word after the longest scan.
        repeat (2 * NUM_BLOCKS + 16) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
